/* design/rbid_pkg.sv */
package rbid_pkg;

   // field widths of the bit stream
   localparam int unsigned COUNT_FLD_BIT = 5;
   localparam int unsigned OP_BIT        = 3;
   localparam int unsigned OPND_TYPE_BIT = 2;
   localparam int unsigned VAL_BIT       = 8;
   localparam int unsigned STK_BIT       = 5;
   localparam int unsigned REG_BIT       = 3;
   localparam int unsigned LABEL_FLD_BIT = 3;

   // token kinds on the result channel
   localparam logic [2:0] KIND_COUNT  = 3'd0;
   localparam logic [2:0] KIND_OPCODE = 3'd1;
   localparam logic [2:0] KIND_TYPE   = 3'd2;
   localparam logic [2:0] KIND_VALUE  = 3'd3;
   localparam logic [2:0] KIND_LABEL  = 3'd4;

   // operand type codes
   localparam logic [1:0] OPND_IMM = 2'd0;
   localparam logic [1:0] OPND_REG = 2'd1;

   // operands taken by each opcode: 0, 3 and 4 take two, 2 takes none, the rest one
   localparam logic [1:0] OPERAND_COUNT [8] = '{
      2'd2, 2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1
   };

   // next field expected in the stream
   typedef enum logic [6:0] {
      FLD_COUNT  = 7'b0000001,
      FLD_OPCODE = 7'b0000010,
      FLD_TYPE   = 7'b0000100,
      FLD_VAL    = 7'b0001000,
      FLD_REG    = 7'b0010000,
      FLD_SLOT   = 7'b0100000,
      FLD_LABEL  = 7'b1000000
   } field_type;

   // one queued input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } queue_beat_type;

   // queue head as seen by the back part
   typedef struct packed {
      logic           valid;
      queue_beat_type beat;
   } queue_head_type;

   function automatic logic [3:0] field_width(input field_type fld);
      logic [3:0] w;
      case (fld)
         FLD_COUNT:  w = 4'(COUNT_FLD_BIT);
         FLD_OPCODE: w = 4'(OP_BIT);
         FLD_TYPE:   w = 4'(OPND_TYPE_BIT);
         FLD_VAL:    w = 4'(VAL_BIT);
         FLD_REG:    w = 4'(REG_BIT);
         FLD_SLOT:   w = 4'(STK_BIT);
         FLD_LABEL:  w = 4'(LABEL_FLD_BIT);
         default:    w = 4'(COUNT_FLD_BIT);
      endcase
      return w;
   endfunction

endpackage

/* design/rbid_front.sv */
module rbid_front #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_final_byte,
   output rbid_pkg::queue_head_type      q_head,
   input  logic                          q_pop
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   rbid_pkg::queue_beat_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   // stall only on a full queue
   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != '0);

   assign q_head.valid = (count_ff != '0);
   assign q_head.beat  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // beat storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].data_byte  <= req_data_byte;
         slot_ff[wr_ptr_ff].final_byte <= req_final_byte;
      end
   end

endmodule

/* design/rbid_back.sv */
module rbid_back (
   input  logic                     clock,
   input  logic                     reset,
   input  rbid_pkg::queue_head_type q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_token_kind,
   output logic [7:0]               rsp_token_value,
   output logic                     rsp_run_last,
   output logic                     rsp_stream_done
);

   // decode state
   logic [14:0]         store_ff, store_in;
   logic [3:0]          held_ff, held_in;
   rbid_pkg::field_type fld_ff, fld_in;
   logic [4:0]          ins_ff, ins_in;
   logic [1:0]          ops_ff, ops_in;
   logic                fin_ff, fin_in;
   logic                busy_ff, busy_in;
   logic                last_ff, last_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          kind_ff, kind_in;
   logic [7:0]          value_ff, value_in;
   logic                run_last_ff, run_last_in;
   logic                done_ff, done_in;

   logic                out_free;
   logic [3:0]          w;
   logic                have;
   logic [7:0]          v;
   logic [14:0]         store_sh;
   logic [3:0]          held_sh;
   rbid_pkg::field_type fld_nx;
   logic [4:0]          ins_nx;
   logic [1:0]          ops_nx;
   logic [2:0]          kind_nx;
   logic                stop;
   logic                tok_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign w        = rbid_pkg::field_width(fld_ff);
   assign have     = (held_ff >= w);
   assign store_sh = store_ff >> w;
   assign held_sh  = held_ff - w;

   // field extraction and next-field selection
   always_comb begin
      ins_nx  = ins_ff;
      ops_nx  = ops_ff;
      stop    = 1'b0;
      kind_nx = rbid_pkg::KIND_VALUE;
      fld_nx  = rbid_pkg::FLD_COUNT;
      v       = store_ff[7:0];
      case (fld_ff)
         rbid_pkg::FLD_COUNT: begin
            v       = {3'd0, store_ff[4:0]};
            kind_nx = rbid_pkg::KIND_COUNT;
            ins_nx  = store_ff[4:0];
            fld_nx  = (ins_nx != '0) ? rbid_pkg::FLD_OPCODE : rbid_pkg::FLD_LABEL;
         end
         rbid_pkg::FLD_OPCODE: begin
            v       = {5'd0, store_ff[2:0]};
            kind_nx = rbid_pkg::KIND_OPCODE;
            ins_nx  = ins_ff - 5'd1;
            ops_nx  = rbid_pkg::OPERAND_COUNT[store_ff[2:0]];
            if (ops_nx != '0) begin
               fld_nx = rbid_pkg::FLD_TYPE;
            end else begin
               fld_nx = (ins_nx != '0) ? rbid_pkg::FLD_OPCODE : rbid_pkg::FLD_LABEL;
            end
         end
         rbid_pkg::FLD_TYPE: begin
            v       = {6'd0, store_ff[1:0]};
            kind_nx = rbid_pkg::KIND_TYPE;
            case (store_ff[1:0])
               rbid_pkg::OPND_IMM: fld_nx = rbid_pkg::FLD_VAL;
               rbid_pkg::OPND_REG: fld_nx = rbid_pkg::FLD_REG;
               default:            fld_nx = rbid_pkg::FLD_SLOT;
            endcase
         end
         rbid_pkg::FLD_LABEL: begin
            v       = {5'd0, store_ff[2:0]};
            kind_nx = rbid_pkg::KIND_LABEL;
            stop    = last_ff;
            fld_nx  = rbid_pkg::FLD_COUNT;
         end
         rbid_pkg::FLD_VAL, rbid_pkg::FLD_REG, rbid_pkg::FLD_SLOT: begin
            if (fld_ff == rbid_pkg::FLD_REG) begin
               v = {5'd0, store_ff[2:0]};
            end else if (fld_ff == rbid_pkg::FLD_SLOT) begin
               v = {3'd0, store_ff[4:0]};
            end
            kind_nx = rbid_pkg::KIND_VALUE;
            ops_nx  = ops_ff - 2'd1;
            if (ops_nx != '0) begin
               fld_nx = rbid_pkg::FLD_TYPE;
            end else begin
               fld_nx = (ins_ff != '0) ? rbid_pkg::FLD_OPCODE : rbid_pkg::FLD_LABEL;
            end
         end
         default: begin
            fld_nx = rbid_pkg::FLD_COUNT;
         end
      endcase
      // last token of the beat when the stream stops or the next field is short
      tok_last = stop || (held_sh < rbid_pkg::field_width(fld_nx));
   end

   // sequencing: load a beat, then one field per cycle while the result register is free
   always_comb begin
      store_in     = store_ff;
      held_in      = held_ff;
      fld_in       = fld_ff;
      ins_in       = ins_ff;
      ops_in       = ops_ff;
      fin_in       = fin_ff;
      busy_in      = busy_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      value_in     = value_ff;
      run_last_in  = run_last_ff;
      done_in      = done_ff;
      if (!busy_ff) begin
         q_pop = q_head.valid;
         // after the end of the stream beats are dropped
         if (q_head.valid && !fin_ff) begin
            store_in = store_ff | (15'(q_head.beat.data_byte) << held_ff);
            held_in  = held_ff + 4'd8;
            last_in  = q_head.beat.final_byte;
            busy_in  = 1'b1;
         end
      end else if (!have) begin
         // beat gave no token
         busy_in = 1'b0;
         if (last_ff) begin
            fin_in   = 1'b1;
            store_in = '0;
            held_in  = '0;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b1;
         kind_in      = kind_nx;
         value_in     = v;
         run_last_in  = tok_last;
         done_in      = stop;
         store_in     = store_sh;
         held_in      = held_sh;
         fld_in       = fld_nx;
         ins_in       = ins_nx;
         ops_in       = ops_nx;
         if (tok_last) begin
            busy_in = 1'b0;
            if (last_ff) begin
               fin_in   = 1'b1;
               store_in = '0;
               held_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff     <= '0;
         held_ff      <= '0;
         fld_ff       <= rbid_pkg::FLD_COUNT;
         ins_ff       <= '0;
         ops_ff       <= '0;
         fin_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         store_ff     <= store_in;
         held_ff      <= held_in;
         fld_ff       <= fld_in;
         ins_ff       <= ins_in;
         ops_ff       <= ops_in;
         fin_ff       <= fin_in;
         busy_ff      <= busy_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      run_last_ff <= run_last_in;
      done_ff     <= done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_token_value = value_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_stream_done = done_ff;

endmodule

/* design/reverse_bitfield_instruction_decoder_core.sv */
// Decodes a program image fed from its last byte to its first into one token per
// bit field (count, opcode, operand type, operand value, function label). Input
// beats land in a QUEUE_DEPTH-entry queue; the decode engine behind it loads a
// byte into its 15-bit bit store and then emits one token per field, since a
// single field extractor handles one field per cycle while the result register
// is free. While a token waits in the result register the engine can still load
// the next byte, but it emits no further token until the waiting one is taken.
// run_last marks the last token of each byte; stream_done marks the label taken
// from the final byte. After the final byte every further beat is accepted and
// dropped until reset.
module reverse_bitfield_instruction_decoder_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_token_value,
   output logic       rsp_run_last,
   output logic       rsp_stream_done
);

   rbid_pkg::queue_head_type q_head;
   logic                     q_pop;

   rbid_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_head         (q_head),
      .q_pop          (q_pop)
   );

   rbid_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_value (rsp_token_value),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

   // engine never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("queue popped while empty");

   // end of stream is always a label and closes its beat
   a_done_is_label: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_done) |->
         (rsp_run_last && rsp_token_kind == rbid_pkg::KIND_LABEL))
      else $error("stream_done on a token that is not a closing label");

   // nothing follows the final label
   a_quiet_after_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_done && !rsp_stall) |=> !rsp_valid)
      else $error("token after end of stream");

endmodule
